@@ rtl/ttf_pkg.sv @@
// Shared types and constants for the triangle tangent frame block.
// Used by ttf_norm and triangle_tangent_frame; depends on nothing.
`default_nettype none
package ttf_pkg;

    // The largest component magnitude is scaled into [2^29, 2^30).
    localparam int NORM_BITS    = 30;
    localparam int SQ_BITS      = 2 * NORM_BITS;
    localparam int SUM_BITS     = 62;
    localparam int ROOT_BITS    = 31;
    localparam int ISQ_REM_BITS = 35;
    localparam int DIV_REM_BITS = ROOT_BITS + 1;

    typedef struct packed {
        logic valid;
        logic flag;
    } ttf_ctl_t;

endpackage
`default_nettype wire

@@ rtl/ttf_norm.sv @@
// Pipelined normalizer: scales a three-component magnitude vector to unit length.
// Uses ttf_pkg; a bit-serial square root and three restoring dividers, one bit per stage.
`default_nettype none
module ttf_norm
    import ttf_pkg::*;
#(
    parameter int MAG_BITS = 38,
    parameter int OUT_BITS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ttf_ctl_t              in_ctl,
    input  wire logic [MAG_BITS-1:0]   in_mag [3],
    input  wire logic [2:0]            in_neg,
    output ttf_ctl_t                   out_ctl,
    output logic                       out_zero,
    output logic [3*OUT_BITS-1:0]      out_vec
);

    localparam int FRAC    = OUT_BITS - 2;
    localparam int QB      = FRAC + 2;
    localparam int SH_BITS = $clog2(MAG_BITS + 1);
    localparam int EXT     = MAG_BITS + NORM_BITS;

    // Stage 1: leading-one search over the OR of the magnitudes.
    logic [MAG_BITS-1:0] any_mag;
    logic [SH_BITS-1:0]  sh_next;

    always_comb
    begin
        any_mag = in_mag[0] | in_mag[1] | in_mag[2];
        sh_next = '0;
        for (int k = 0; k < MAG_BITS; k++)
        begin
            if (any_mag[k])
            begin
                sh_next = SH_BITS'(k + 1);
            end
        end
    end

    ttf_ctl_t            ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg;
    logic [MAG_BITS-1:0] m1_reg [3];
    logic [2:0]          neg1_reg, neg2_reg, neg3_reg, neg4_reg;
    logic                zero1_reg, zero2_reg, zero3_reg, zero4_reg;
    logic [SH_BITS-1:0]  sh1_reg;
    logic [NORM_BITS-1:0] m2_reg [3];
    logic [NORM_BITS-1:0] m3_reg [3];
    logic [NORM_BITS-1:0] m4_reg [3];
    logic [SQ_BITS-1:0]  sq3_reg [3];
    logic [SUM_BITS-1:0] sum4_reg;
    logic [EXT-1:0]      ext2 [3];

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            ext2[l] = {m1_reg[l], NORM_BITS'(0)} >> sh1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
        end
        else
        begin
            ctl1_reg <= in_ctl;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 3; l++)
        begin
            m1_reg[l]  <= in_mag[l];
            m2_reg[l]  <= ext2[l][NORM_BITS-1:0];
            m3_reg[l]  <= m2_reg[l];
            sq3_reg[l] <= SQ_BITS'(m2_reg[l]) * SQ_BITS'(m2_reg[l]);
            m4_reg[l]  <= m3_reg[l];
        end
        neg1_reg  <= in_neg;
        zero1_reg <= (any_mag == '0);
        sh1_reg   <= sh_next;
        neg2_reg  <= neg1_reg;
        zero2_reg <= zero1_reg;
        neg3_reg  <= neg2_reg;
        zero3_reg <= zero2_reg;
        neg4_reg  <= neg3_reg;
        zero4_reg <= zero3_reg;
        sum4_reg  <= SUM_BITS'(sq3_reg[0]) + SUM_BITS'(sq3_reg[1]) + SUM_BITS'(sq3_reg[2]);
    end

    // Square root, one result bit per stage.
    ttf_ctl_t                isq_ctl  [ROOT_BITS+1];
    logic [ROOT_BITS-1:0]    isq_root [ROOT_BITS+1];
    logic [ISQ_REM_BITS-1:0] isq_rem  [ROOT_BITS+1];
    logic [SUM_BITS-1:0]     isq_sum  [ROOT_BITS+1];
    logic [NORM_BITS-1:0]    isq_m    [ROOT_BITS+1][3];
    logic [2:0]              isq_neg  [ROOT_BITS+1];
    logic                    isq_zero [ROOT_BITS+1];

    assign isq_ctl[0]  = ctl4_reg;
    assign isq_root[0] = '0;
    assign isq_rem[0]  = '0;
    assign isq_sum[0]  = sum4_reg;
    assign isq_m[0]    = m4_reg;
    assign isq_neg[0]  = neg4_reg;
    assign isq_zero[0] = zero4_reg;

    for (genvar i = 0; i < ROOT_BITS; i++)
    begin : g_isq
        localparam int B = ROOT_BITS - 1 - i;
        logic [ISQ_REM_BITS-1:0] cur;
        logic [ISQ_REM_BITS-1:0] trial;
        logic                    take;

        always_comb
        begin
            cur   = {isq_rem[i][ISQ_REM_BITS-3:0], isq_sum[i][2*B+1 -: 2]};
            trial = {ISQ_REM_BITS'(isq_root[i]) << 2} | ISQ_REM_BITS'(1);
            take  = (cur >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                isq_ctl[i+1] <= '0;
            end
            else
            begin
                isq_ctl[i+1] <= isq_ctl[i];
            end
        end

        always_ff @(posedge clk)
        begin
            isq_rem[i+1]  <= take ? (cur - trial) : cur;
            isq_root[i+1] <= {isq_root[i][ROOT_BITS-2:0], take};
            isq_sum[i+1]  <= isq_sum[i];
            isq_m[i+1]    <= isq_m[i];
            isq_neg[i+1]  <= isq_neg[i];
            isq_zero[i+1] <= isq_zero[i];
        end
    end

    // Three restoring dividers, one quotient bit per stage.
    ttf_ctl_t                div_ctl  [QB+1];
    logic [ROOT_BITS-1:0]    div_len  [QB+1];
    logic [DIV_REM_BITS-1:0] div_rem  [QB+1][3];
    logic [QB-1:0]           div_q    [QB+1][3];
    logic [2:0]              div_neg  [QB+1];
    logic                    div_zero [QB+1];

    assign div_ctl[0]  = isq_ctl[ROOT_BITS];
    assign div_len[0]  = isq_root[ROOT_BITS];
    assign div_neg[0]  = isq_neg[ROOT_BITS];
    assign div_zero[0] = isq_zero[ROOT_BITS];

    for (genvar l = 0; l < 3; l++)
    begin : g_div_init
        assign div_rem[0][l] = DIV_REM_BITS'(isq_m[ROOT_BITS][l]);
        assign div_q[0][l]   = '0;
    end

    for (genvar j = 0; j < QB; j++)
    begin : g_div
        logic [DIV_REM_BITS-1:0] cur [3];
        logic [2:0]              take;

        always_comb
        begin
            for (int l = 0; l < 3; l++)
            begin
                if (j == 0)
                begin
                    cur[l] = div_rem[j][l];
                end
                else
                begin
                    cur[l] = {div_rem[j][l][DIV_REM_BITS-2:0], 1'b0};
                end
                take[l] = (cur[l] >= DIV_REM_BITS'(div_len[j]));
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_ctl[j+1] <= '0;
            end
            else
            begin
                div_ctl[j+1] <= div_ctl[j];
            end
        end

        always_ff @(posedge clk)
        begin
            for (int l = 0; l < 3; l++)
            begin
                div_rem[j+1][l] <= take[l] ? (cur[l] - DIV_REM_BITS'(div_len[j])) : cur[l];
                div_q[j+1][l]   <= {div_q[j][l][QB-2:0], take[l]};
            end
            div_len[j+1]  <= div_len[j];
            div_neg[j+1]  <= div_neg[j];
            div_zero[j+1] <= div_zero[j];
        end
    end

    // Final stage: round half away from zero, saturate, apply sign.
    logic [3*OUT_BITS-1:0] vec_next;
    logic [QB:0]           rnd [3];
    logic [OUT_BITS-1:0]   qv  [3];

    always_comb
    begin
        vec_next = '0;
        for (int l = 0; l < 3; l++)
        begin
            rnd[l] = ({1'b0, div_q[QB][l]} + (QB+1)'(1)) >> 1;
            qv[l]  = rnd[l][OUT_BITS-1:0];
            if (qv[l] > (OUT_BITS'(1) << FRAC))
            begin
                qv[l] = OUT_BITS'(1) << FRAC;
            end
            if (div_neg[QB][l])
            begin
                qv[l] = OUT_BITS'(0) - qv[l];
            end
            vec_next[OUT_BITS*(3-l)-1 -: OUT_BITS] = qv[l];
        end
        if (div_zero[QB])
        begin
            vec_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ctl <= '0;
        end
        else
        begin
            out_ctl <= div_ctl[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        out_vec  <= vec_next;
        out_zero <= div_zero[QB];
    end

endmodule
`default_nettype wire

@@ rtl/triangle_tangent_frame.sv @@
// Throughput: one triangle per cycle; busy stays low and results cannot be held off.
// The depth is set by the square root (31 stages) and the dividers (OUT_BITS stages).
// Reset clears all valid bits asynchronously; no results are in flight after reset.
// Top level of the triangle tangent frame block; uses ttf_pkg and ttf_norm.
`default_nettype none
module triangle_tangent_frame
    import ttf_pkg::*;
#(
    parameter int COORD_BITS = 20,
    parameter int UV_BITS    = 16,
    parameter int OUT_BITS   = 16
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [3*COORD_BITS-1:0] first_position,
    input  wire logic [3*COORD_BITS-1:0] apex_position,
    input  wire logic [3*COORD_BITS-1:0] third_position,
    input  wire logic [2*UV_BITS-1:0]    first_uv,
    input  wire logic [2*UV_BITS-1:0]    apex_uv,
    input  wire logic [2*UV_BITS-1:0]    third_uv,
    output logic                         done,
    output logic [3*OUT_BITS-1:0]        tangent,
    output logic [3*OUT_BITS-1:0]        bitangent,
    output logic                         degenerate
);

    localparam int EB   = COORD_BITS + 1;
    localparam int DB   = UV_BITS + 1;
    localparam int PB   = EB + DB;
    localparam int VB   = PB + 1;
    localparam int DETB = 2 * DB + 1;

    assign busy = 1'b0;

    // Stage 1: edge and texture deltas.
    logic                   v1_reg;
    logic signed [EB-1:0]   e1_reg [3];
    logic signed [EB-1:0]   e2_reg [3];
    logic signed [DB-1:0]   d1u_reg, d1v_reg, d2u_reg, d2v_reg;

    // Stage 2: products.
    logic                   v2_reg;
    logic signed [PB-1:0]   ta_reg [3];
    logic signed [PB-1:0]   tb_reg [3];
    logic signed [PB-1:0]   ba_reg [3];
    logic signed [PB-1:0]   bb_reg [3];
    logic signed [2*DB-1:0] dp_reg, dq_reg;

    // Stage 3: vector components, determinant sign, magnitudes.
    ttf_ctl_t               ctl3_reg;
    logic [PB-1:0]          tm3_reg [3];
    logic [PB-1:0]          bm3_reg [3];
    logic [2:0]             tn3_reg, bn3_reg;

    logic signed [VB-1:0]   tv [3];
    logic signed [VB-1:0]   bv [3];
    logic signed [DETB-1:0] det;
    logic                   det_neg;
    logic [2:0]             tn_next, bn_next;
    logic [VB-1:0]          tabs [3];
    logic [VB-1:0]          babs [3];

    always_comb
    begin
        det     = DETB'(dp_reg) - DETB'(dq_reg);
        det_neg = det[DETB-1];
        for (int i = 0; i < 3; i++)
        begin
            tv[i]      = VB'(ta_reg[i]) - VB'(tb_reg[i]);
            bv[i]      = VB'(ba_reg[i]) - VB'(bb_reg[i]);
            tn_next[i] = tv[i][VB-1] ^ det_neg;
            bn_next[i] = bv[i][VB-1] ^ det_neg;
            tabs[i]    = tv[i][VB-1] ? (VB'(0) - VB'(tv[i])) : VB'(tv[i]);
            babs[i]    = bv[i][VB-1] ? (VB'(0) - VB'(bv[i])) : VB'(bv[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            ctl3_reg <= '0;
        end
        else
        begin
            v1_reg         <= start && !busy;
            v2_reg         <= v1_reg;
            ctl3_reg.valid <= v2_reg;
            ctl3_reg.flag  <= (det == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            e1_reg[i] <= EB'($signed(first_position[COORD_BITS*(3-i)-1 -: COORD_BITS]))
                       - EB'($signed(apex_position[COORD_BITS*(3-i)-1 -: COORD_BITS]));
            e2_reg[i] <= EB'($signed(third_position[COORD_BITS*(3-i)-1 -: COORD_BITS]))
                       - EB'($signed(apex_position[COORD_BITS*(3-i)-1 -: COORD_BITS]));
            ta_reg[i] <= PB'(d2v_reg) * PB'(e1_reg[i]);
            tb_reg[i] <= PB'(d1v_reg) * PB'(e2_reg[i]);
            ba_reg[i] <= PB'(d1u_reg) * PB'(e2_reg[i]);
            bb_reg[i] <= PB'(d2u_reg) * PB'(e1_reg[i]);
            tm3_reg[i] <= tabs[i][PB-1:0];
            bm3_reg[i] <= babs[i][PB-1:0];
        end
        d1u_reg <= DB'($signed(first_uv[2*UV_BITS-1 -: UV_BITS]))
                 - DB'($signed(apex_uv[2*UV_BITS-1 -: UV_BITS]));
        d1v_reg <= DB'($signed(first_uv[UV_BITS-1:0])) - DB'($signed(apex_uv[UV_BITS-1:0]));
        d2u_reg <= DB'($signed(third_uv[2*UV_BITS-1 -: UV_BITS]))
                 - DB'($signed(apex_uv[2*UV_BITS-1 -: UV_BITS]));
        d2v_reg <= DB'($signed(third_uv[UV_BITS-1:0])) - DB'($signed(apex_uv[UV_BITS-1:0]));
        dp_reg  <= (2*DB)'(d1u_reg) * (2*DB)'(d2v_reg);
        dq_reg  <= (2*DB)'(d2u_reg) * (2*DB)'(d1v_reg);
        tn3_reg <= tn_next;
        bn3_reg <= bn_next;
    end

    ttf_ctl_t              t_ctl, b_ctl;
    logic                  t_zero, b_zero;
    logic [3*OUT_BITS-1:0] t_vec, b_vec;

    ttf_norm #(
        .MAG_BITS (PB),
        .OUT_BITS (OUT_BITS)
    ) u_norm_t (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ctl   (ctl3_reg),
        .in_mag   (tm3_reg),
        .in_neg   (tn3_reg),
        .out_ctl  (t_ctl),
        .out_zero (t_zero),
        .out_vec  (t_vec)
    );

    ttf_norm #(
        .MAG_BITS (PB),
        .OUT_BITS (OUT_BITS)
    ) u_norm_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ctl   (ctl3_reg),
        .in_mag   (bm3_reg),
        .in_neg   (bn3_reg),
        .out_ctl  (b_ctl),
        .out_zero (b_zero),
        .out_vec  (b_vec)
    );

    logic                  done_reg;
    logic [3*OUT_BITS-1:0] tangent_reg, bitangent_reg;
    logic                  degenerate_reg;
    logic                  bad;

    assign bad = t_ctl.flag | b_ctl.flag | t_zero | b_zero;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= t_ctl.valid & b_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        tangent_reg    <= bad ? '0 : t_vec;
        bitangent_reg  <= bad ? '0 : b_vec;
        degenerate_reg <= bad;
    end

    assign done       = done_reg;
    assign tangent    = tangent_reg;
    assign bitangent  = bitangent_reg;
    assign degenerate = degenerate_reg;

endmodule
`default_nettype wire
